[rtl/htfc_pkg.sv]
// Package for the humidity/temperature frame checker: frame constants,
// byte-wide reflected CRC-16 update, divide-by-ten and shared structs.
// No dependencies.
package htfc_pkg;

	localparam logic [3:0]  IDX_FIRST   = 4'd0;
	localparam logic [3:0]  IDX_HUM_HI  = 4'd2;
	localparam logic [3:0]  IDX_CRC_BEG = 4'd5;
	localparam logic [3:0]  IDX_CRC_LO  = 4'd6;
	localparam logic [3:0]  IDX_CRC_HI  = 4'd7;
	localparam logic [3:0]  IDX_IDLE    = 4'd8;
	localparam int          FRAME_REGS  = 5;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [15:0] DIV10_RECIP = 16'hCCCD;

	typedef struct packed {
		logic [7:0] hum_hi;
		logic [7:0] hum_lo;
		logic [7:0] tmp_hi;
		logic [7:0] tmp_lo;
	} frame_t;

	typedef struct packed {
		logic [12:0]        humidity;
		logic signed [12:0] temperature;
	} meas_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// floor(x / 10) for any 16-bit x by reciprocal multiply
	function automatic logic [12:0] div10(input logic [15:0] x);
		logic [31:0] p;
		p = 32'(x) * 32'(DIV10_RECIP);
		return p[31:19];
	endfunction

endpackage

[rtl/htfc_in_if.sv]
// Request channel into the frame checker: one received sensor byte per request.
// Depends on nothing.
interface htfc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;

	modport source (output valid, rx_byte, frame_start, input ready);
	modport sink   (input valid, rx_byte, frame_start, output ready);
endinterface

[rtl/htfc_out_if.sv]
// Result channel of the frame checker: decoded humidity, temperature, CRC status.
// Depends on nothing.
interface htfc_out_if;
	logic               valid;
	logic               ready;
	logic [12:0]        humidity;
	logic signed [12:0] temperature;
	logic               crc_ok;

	modport source (output valid, humidity, temperature, crc_ok, input ready);
	modport sink   (input valid, humidity, temperature, crc_ok, output ready);
endinterface

[rtl/htfc_decode.sv]
// Measurement decode: humidity word and signed temperature, each divided by ten.
// Depends on htfc_pkg.
module htfc_decode
	import htfc_pkg::*;
(
	input  frame_t frame,
	output meas_t  meas
);

	logic [15:0] hum_word;
	logic [15:0] tmp_mag;
	logic [12:0] tmp_div;

	assign hum_word = {frame.hum_hi, frame.hum_lo};
	assign tmp_mag  = {1'b0, frame.tmp_hi[6:0], frame.tmp_lo};
	assign tmp_div  = div10(tmp_mag);

	always_comb begin
		meas.humidity = div10(hum_word);
		if (frame.tmp_hi[7]) begin
			meas.temperature = $signed(13'd0 - tmp_div);
		end else begin
			meas.temperature = $signed(tmp_div);
		end
	end

endmodule

[rtl/humidity_temp_frame_checker_unit.sv]
// A request passes stage s1, then the result register; a result is produced on the frame's eighth byte.
// Throughput: one byte per cycle; stalls only while a result waits at the output.
// Stage s1 holds the request; CRC, frame capture and decode run from s1 into
// the result register. arst_n clears control state, CRC to 0xFFFF, index to idle
// and the held measurements to zero.
module humidity_temp_frame_checker_unit
	import htfc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	htfc_in_if.sink    rx,
	htfc_out_if.source res
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic [3:0]  index_q;
	logic [15:0] crc_q;
	logic [7:0]  frame_q [FRAME_REGS];
	logic [12:0] last_hum_q;
	logic [12:0] last_tmp_q;
	logic        out_valid_q;
	logic [12:0] out_hum_q;
	logic [12:0] out_tmp_q;
	logic        out_ok_q;

	logic [3:0]  idx;
	logic [15:0] crc_base;
	logic        is_result;
	logic        advance;
	logic        crc_match;
	logic [2:0]  slot;
	frame_t      frame;
	meas_t       meas;

	assign idx       = start_s1 ? IDX_FIRST : index_q;
	assign crc_base  = start_s1 ? CRC_INIT : crc_q;
	assign is_result = (idx == IDX_CRC_HI);
	assign advance   = valid_s1 && (!is_result || !out_valid_q || res.ready);
	assign rx.ready  = !valid_s1 || advance;
	assign crc_match = ({byte_s1, frame_q[4]} == crc_q);
	assign slot      = idx[2:0] - IDX_HUM_HI[2:0];

	assign frame.hum_hi = frame_q[0];
	assign frame.hum_lo = frame_q[1];
	assign frame.tmp_hi = frame_q[2];
	assign frame.tmp_lo = frame_q[3];

	htfc_decode u_decode (
		.frame (frame),
		.meas  (meas)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1  <= rx.rx_byte;
			start_s1 <= rx.frame_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q    <= IDX_IDLE;
			crc_q      <= CRC_INIT;
			last_hum_q <= '0;
			last_tmp_q <= '0;
		end else if (advance && idx < IDX_IDLE) begin
			if (idx <= IDX_CRC_BEG) begin
				crc_q <= crc_update(crc_base, byte_s1);
			end
			if (is_result) begin
				index_q <= IDX_IDLE;
				crc_q   <= CRC_INIT;
				if (crc_match) begin
					last_hum_q <= meas.humidity;
					last_tmp_q <= meas.temperature;
				end
			end else begin
				index_q <= idx + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && idx >= IDX_HUM_HI && idx <= IDX_CRC_LO) begin
			frame_q[slot] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_result) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_result) begin
			out_ok_q <= crc_match;
			if (crc_match) begin
				out_hum_q <= meas.humidity;
				out_tmp_q <= meas.temperature;
			end else begin
				out_hum_q <= last_hum_q;
				out_tmp_q <= last_tmp_q;
			end
		end
	end

	assign res.valid       = out_valid_q;
	assign res.humidity    = out_hum_q;
	assign res.temperature = $signed(out_tmp_q);
	assign res.crc_ok      = out_ok_q;

`ifndef ASSERT_OFF
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		index_q <= IDX_IDLE)
		else $error("frame index out of range");

	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_result |=> index_q == IDX_IDLE && crc_q == CRC_INIT)
		else $error("frame not closed after result");

	a_good_matches_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_ok_q |-> out_hum_q == last_hum_q && out_tmp_q == last_tmp_q)
		else $error("good result differs from held measurement");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> valid_s1 && is_result && out_valid_q)
		else $error("request stalled without a pending result");
`endif

endmodule
